>>> sv/srb_pkg.sv
// ---------------------------------------------------------------------------
// srb_pkg
// Shared codes, types and state encoding for the SRAM bank with dirty pages.
// ---------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  // Fault codes
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ADDR = 2'd1;
  localparam logic [1:0] FAULT_BUS  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RAM_ENABLED     = 3'd0;
  localparam logic [2:0] CFG_SIZE_LOG2       = 3'd1;
  localparam logic [2:0] CFG_CHECK_ALIGNMENT = 3'd2;
  localparam logic [2:0] CFG_PROTECT_READS   = 3'd3;
  localparam logic [2:0] CFG_PROTECT_WRITES  = 3'd4;

  // Size window for the address mask
  localparam logic [4:0] SIZE_LOG2_MIN = 5'd10;

  // Page geometry: 1 KiB pages, 8 pages per bitmap byte
  localparam int PAGE_SHIFT = 10;
  localparam int MAP_SHIFT  = 13;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK1,
    ST_MARK2,
    ST_DONE
  } state_t;

  // Byte-lane array request
  typedef struct packed {
    logic       en;
    logic       we;
    logic [1:0] size;
  } lane_ctl_t;

  // Dirty bitmap request
  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [7:0] set_bits;
  } map_ctl_t;

endpackage

`default_nettype wire

>>> sv/srb_ram.sv
// ---------------------------------------------------------------------------
// srb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module srb_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 10
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, read port holds its data until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/srb_lanes.sv
// ---------------------------------------------------------------------------
// srb_lanes
// Four byte-wide RAM lanes holding the bank big-endian; steers bytes of
// byte, word and long accesses (aligned or not) and reassembles reads.
// ---------------------------------------------------------------------------
`default_nettype none

module srb_lanes
  import srb_pkg::*;
#(
  parameter int AW = 16
) (
  input  wire logic       clk,
  input  wire lane_ctl_t  ctl,
  input  wire logic [AW-1:0] addr,   // already masked
  input  wire logic [AW-1:0] mask,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);

  logic [1:0] cnt_m1;
  logic       rd_en;
  logic [7:0] lane_q [4];
  logic [1:0] a0_q;
  logic [1:0] size_q;

  // last byte offset of the access
  always_comb begin
    unique case (ctl.size)
      SIZE_BYTE: cnt_m1 = 2'd0;
      SIZE_WORD: cnt_m1 = 2'd1;
      SIZE_LONG: cnt_m1 = 2'd3;
      default:   cnt_m1 = 2'd0;
    endcase
  end

  assign rd_en = ctl.en && (ctl.we == OP_READ);

  // One lane per low address bit pair
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [1:0]    off;
    logic [1:0]    sel;
    logic          hit;
    logic [AW-1:0] lane_a;
    logic [31:0]   wsh;

    assign off    = 2'(l) - addr[1:0];
    assign hit    = (off <= cnt_m1);
    assign sel    = cnt_m1 - off;
    assign lane_a = (addr + AW'(off)) & mask;
    assign wsh    = wdata >> {sel, 3'b000};

    srb_ram #(
      .WIDTH  (8),
      .ADDR_W (AW - 2)
    ) u_ram (
      .clk   (clk),
      .we    (ctl.en && (ctl.we == OP_WRITE) && hit),
      .waddr (lane_a[AW-1:2]),
      .wdata (wsh[7:0]),
      .re    (rd_en),
      .raddr (lane_a[AW-1:2]),
      .rdata (lane_q[l])
    );
  end

  // Remember alignment and size of the pending read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      a0_q   <= addr[1:0];
      size_q <= ctl.size;
    end
  end

  // Big-endian reassembly: byte at lowest address is most significant
  always_comb begin
    unique case (size_q)
      SIZE_BYTE: rdata = {24'd0, lane_q[a0_q]};
      SIZE_WORD: rdata = {16'd0, lane_q[a0_q], lane_q[a0_q + 2'd1]};
      SIZE_LONG: rdata = {lane_q[a0_q], lane_q[a0_q + 2'd1],
                          lane_q[a0_q + 2'd2], lane_q[a0_q + 2'd3]};
      default:   rdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/srb_dirty_map.sv
// ---------------------------------------------------------------------------
// srb_dirty_map
// Dirty page bitmap in RAM, one bit per 1 KiB page. Read-modify-write:
// a read, then the write ORs new bits into the registered read data.
// Clears itself with a sweep after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module srb_dirty_map
  import srb_pkg::*;
#(
  parameter int MAW = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire map_ctl_t       ctl,
  input  wire logic [MAW-1:0] rd_idx,
  input  wire logic [MAW-1:0] wr_idx,
  output logic                clearing
);

  logic [MAW-1:0] clr_idx;
  logic [7:0]     map_q;
  logic           we;
  logic [MAW-1:0] waddr;
  logic [7:0]     wdata;

  // Clearing sweep, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (&clr_idx) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write side: sweep zeros, else merge new dirty bits
  assign we    = clearing || ctl.wr;
  assign waddr = clearing ? clr_idx : wr_idx;
  assign wdata = clearing ? 8'd0 : (map_q | ctl.set_bits);

  srb_ram #(
    .WIDTH  (8),
    .ADDR_W (MAW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.rd),
    .raddr (rd_idx),
    .rdata (map_q)
  );

endmodule

`default_nettype wire

>>> sv/sram_bank_with_dirty_pages.sv
// ---------------------------------------------------------------------------
// sram_bank_with_dirty_pages
// Big-endian SRAM bank with byte/word/long access, fault checks and a
// dirty page bitmap.
// ---------------------------------------------------------------------------
// One word in at a time. A read, a faulting access, a disabled bank or
// an unused size goes from idle straight to the done state; a write
// passes through ST_MARK1 first, and a long write whose two pages sit in
// different bitmap bytes through ST_MARK1 and ST_MARK2. The mark states
// serve the dirty bitmap read-modify-write through its single RAM read
// port; the byte lanes finish every access in the accept cycle. ST_DONE
// loads the result register once the output is free and returns to idle.
// A new word is accepted while the previous result still waits at the
// output. After reset the bitmap is swept to zero, one byte per cycle,
// over its 2^(ADDR_BITS-13) bytes (2 at the smallest size); no word is
// accepted meanwhile. Configuration writes are taken at any time.
// ---------------------------------------------------------------------------
`default_nettype none

module sram_bank_with_dirty_pages
  import srb_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] address,
  input  wire logic [31:0] write_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] read_data,
  output logic      [1:0]  fault,
  output logic             pages_marked,
  output logic      [5:0]  first_page,
  output logic      [5:0]  second_page
);

  localparam int AW  = ADDR_BITS;
  localparam int MAW = (ADDR_BITS > MAP_SHIFT) ? (ADDR_BITS - MAP_SHIFT) : 1;

  // Configuration registers
  logic       ram_enabled;
  logic [4:0] size_log2;
  logic       check_alignment;
  logic       protect_reads;
  logic       protect_writes;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled     <= 1'b1;
      size_log2       <= 5'd16;
      check_alignment <= 1'b1;
      protect_reads   <= 1'b0;
      protect_writes  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAM_ENABLED:     ram_enabled     <= cfg_data[0];
        CFG_SIZE_LOG2:       size_log2       <= cfg_data;
        CFG_CHECK_ALIGNMENT: check_alignment <= cfg_data[0];
        CFG_PROTECT_READS:   protect_reads   <= cfg_data[0];
        CFG_PROTECT_WRITES:  protect_writes  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Address mask from the clamped size
  logic [4:0]    n_eff;
  logic [AW-1:0] mask;

  always_comb begin
    if (size_log2 < SIZE_LOG2_MIN) begin
      n_eff = SIZE_LOG2_MIN;
    end else if (size_log2 > 5'(AW)) begin
      n_eff = 5'(AW);
    end else begin
      n_eff = size_log2;
    end
    for (int k = 0; k < AW; k++) begin
      mask[k] = (5'(k) < n_eff);
    end
  end

  // Decode of the incoming word
  logic          enabled;
  logic          misalign;
  logic          prot;
  logic          ok;
  logic          wr_ok;
  logic [AW-1:0] am;
  logic [AW-1:0] am2;
  logic [31:0]   am32;
  logic [31:0]   am2_32;
  logic [31:0]   idx1_sh;
  logic [31:0]   idx2_sh;
  logic [1:0]    fault_in;
  logic [MAW-1:0] idx1_in;
  logic [MAW-1:0] idx2_in;

  assign enabled  = ram_enabled && (access_size != SIZE_NONE);
  assign am       = address[AW-1:0] & mask;
  assign am2      = (access_size == SIZE_LONG) ? ((am + AW'(2)) & mask) : am;
  assign am32     = 32'(am);
  assign am2_32   = 32'(am2);
  assign idx1_sh  = am32 >> MAP_SHIFT;
  assign idx2_sh  = am2_32 >> MAP_SHIFT;
  assign idx1_in  = idx1_sh[MAW-1:0];
  assign idx2_in  = idx2_sh[MAW-1:0];
  assign misalign = check_alignment && (access_size != SIZE_BYTE) && address[0];
  assign prot     = (operation == OP_WRITE) ? protect_writes : protect_reads;
  assign ok       = enabled && !misalign && !prot;
  assign wr_ok    = ok && (operation == OP_WRITE);

  always_comb begin
    priority if (!enabled) begin
      fault_in = FAULT_NONE;
    end else if (misalign) begin
      fault_in = FAULT_ADDR;
    end else if (prot) begin
      fault_in = FAULT_BUS;
    end else begin
      fault_in = FAULT_NONE;
    end
  end

  // Sequencer
  state_t    state;
  state_t    state_next;
  logic      accept;
  logic      load;
  logic      clearing;
  lane_ctl_t lane_ctl;
  map_ctl_t  map_ctl;

  // Held item
  logic           is_rd;
  logic [1:0]     fault_q;
  logic           marked_q;
  logic [5:0]     p1_q;
  logic [5:0]     p2_q;
  logic [MAW-1:0] idx1_q;
  logic [MAW-1:0] idx2_q;
  logic [7:0]     bit1_q;
  logic [7:0]     bit2_q;
  logic           two_q;
  logic [31:0]    lane_rdata;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    load             = 1'b0;
    lane_ctl.en      = 1'b0;
    lane_ctl.we      = operation;
    lane_ctl.size    = access_size;
    map_ctl.rd       = 1'b0;
    map_ctl.wr       = 1'b0;
    map_ctl.set_bits = 8'd0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !clearing;
        if (in_valid && !clearing) begin
          lane_ctl.en = ok;
          map_ctl.rd  = wr_ok;
          state_next  = wr_ok ? ST_MARK1 : ST_DONE;
        end
      end
      ST_MARK1: begin
        map_ctl.wr       = 1'b1;
        map_ctl.set_bits = two_q ? bit1_q : (bit1_q | bit2_q);
        map_ctl.rd       = two_q;
        state_next       = two_q ? ST_MARK2 : ST_DONE;
      end
      ST_MARK2: begin
        map_ctl.wr       = 1'b1;
        map_ctl.set_bits = bit2_q;
        state_next       = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture the item at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      is_rd    <= ok && (operation == OP_READ);
      fault_q  <= fault_in;
      marked_q <= wr_ok;
      p1_q     <= wr_ok ? am32[15:10] : 6'd0;
      p2_q     <= wr_ok ? am2_32[15:10] : 6'd0;
      idx1_q   <= idx1_in;
      idx2_q   <= idx2_in;
      bit1_q   <= 8'd1 << am32[12:10];
      bit2_q   <= 8'd1 << am2_32[12:10];
      two_q    <= (idx1_in != idx2_in);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_data    <= is_rd ? lane_rdata : 32'd0;
      fault        <= fault_q;
      pages_marked <= marked_q;
      first_page   <= p1_q;
      second_page  <= p2_q;
    end
  end

  // Byte lanes
  srb_lanes #(
    .AW (AW)
  ) u_lanes (
    .clk   (clk),
    .ctl   (lane_ctl),
    .addr  (am),
    .mask  (mask),
    .wdata (write_data),
    .rdata (lane_rdata)
  );

  // Dirty bitmap
  srb_dirty_map #(
    .MAW (MAW)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .ctl      (map_ctl),
    .rd_idx   ((state == ST_IDLE) ? idx1_in : idx2_q),
    .wr_idx   ((state == ST_MARK2) ? idx2_q : idx1_q),
    .clearing (clearing)
  );

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("sequencer stayed idle after accepting a word");

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("word accepted during bitmap clearing");

  a_fault_is_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (fault != FAULT_NONE)) |-> (!pages_marked && (read_data == 32'd0)))
    else $error("faulting access produced data or marked pages");

  a_pages_zero_unmarked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pages_marked) |-> ((first_page == 6'd0) && (second_page == 6'd0)))
    else $error("page indexes set without marking");

  a_map_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (map_ctl.wr && !clearing) |-> $past(map_ctl.rd))
    else $error("bitmap write without a preceding read");

endmodule

`default_nettype wire
